// File: rtl/rrcs_pkg.sv
// Shared types and fixed field widths of the round-robin completion scheduler.
// No dependencies; imported by the engine, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package rrcs_pkg;

	// Field widths of the input, configuration and result items
	localparam int ARR_W   = 16;
	localparam int BURST_W = 16;
	localparam int QNT_W   = 16;
	localparam int IDXO_W  = 4;
	localparam int TAT_W   = 21;
	localparam int SUM_W   = 25;

	// Quantum after reset
	localparam logic [QNT_W-1:0] QNT_RESET = 16'd4;

	// At most this many completions of one set are reported
	localparam int MAX_RESULTS = 16;
	localparam int EMIT_W      = $clog2(MAX_RESULTS + 1);

	typedef struct packed {
		logic [IDXO_W-1:0] job_index;
		logic [TAT_W-1:0]  turnaround;
		logic [TAT_W-1:0]  waiting;
		logic [SUM_W-1:0]  total_waiting;
		logic [SUM_W-1:0]  total_turnaround;
		logic              last_result;
	} result_t;

endpackage

`default_nettype wire

// File: rtl/rrcs_engine.sv
// Job store and round-robin walk sequencer of the completion scheduler.
// Holds the job memories and the simulation state; depends on rrcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rrcs_engine
	import rrcs_pkg::*;
#(
	parameter int PROCS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [ARR_W-1:0]   arrival_time,
	input  wire logic [BURST_W-1:0] burst_length,
	input  wire logic               is_last_job,
	input  wire logic [QNT_W-1:0]   quantum,
	input  wire logic               res_free,
	output logic                    res_load,
	output result_t                 res
);

	localparam int IDX_W = (PROCS > 1) ? $clog2(PROCS) : 1;
	localparam int CNT_W = $clog2(PROCS + 1);
	localparam int CLK_W = ARR_W + $clog2(PROCS + 1);
	localparam int JOB_W = ARR_W + BURST_W;

	typedef enum logic [9:0] {
		S_LOAD     = 10'b00_0000_0001,
		S_READ     = 10'b00_0000_0010,
		S_EXEC     = 10'b00_0000_0100,
		S_TAT      = 10'b00_0000_1000,
		S_WT       = 10'b00_0001_0000,
		S_OUT      = 10'b00_0010_0000,
		S_NEXT     = 10'b00_0100_0000,
		S_CHECK    = 10'b00_1000_0000,
		S_SCAN_RD  = 10'b01_0000_0000,
		S_SCAN_CMP = 10'b10_0000_0000
	} state_t;

	// Job memories: arrival and burst together, remaining time apart
	logic [JOB_W-1:0]   job_mem [PROCS];
	logic [BURST_W-1:0] rem_mem [PROCS];
	logic [JOB_W-1:0]   job_rd_q;
	logic [BURST_W-1:0] rem_rd_q;

	state_t             state_q;
	logic [IDX_W-1:0]   slot_q;
	logic [IDX_W-1:0]   scan_q;
	logic [CNT_W-1:0]   nload_q;
	logic [CNT_W-1:0]   left_q;
	logic [CLK_W-1:0]   clock_q;
	logic [SUM_W-1:0]   wsum_q;
	logic [SUM_W-1:0]   tsum_q;
	logic [PROCS-1:0]   fin_q;
	logic               prog_q;
	logic [ARR_W-1:0]   best_q;
	logic               found_q;
	logic [CLK_W-1:0]   tat_q;
	logic [CLK_W-1:0]   wt_q;
	logic [EMIT_W-1:0]  emit_q;

	logic               rd_en;
	logic [IDX_W-1:0]   rd_addr;
	logic               rem_we;
	logic [IDX_W-1:0]   rem_addr;
	logic [BURST_W-1:0] rem_wdata;
	logic               load_acc;
	logic               set_close;
	logic [CNT_W-1:0]   nload_inc;
	logic [ARR_W-1:0]   arr_rd;
	logic [BURST_W-1:0] burst_rd;
	logic [BURST_W-1:0] q_eff;
	logic [BURST_W-1:0] run;
	logic [BURST_W-1:0] rem_new;
	logic               runnable;
	logic [CNT_W-1:0]   slot_inc;
	logic [CNT_W-1:0]   scan_inc;
	logic               arr_due;
	logic               scan_hit;
	logic [ARR_W-1:0]   best_nxt;
	logic               found_nxt;
	logic [SUM_W-1:0]   wsum_nxt;
	logic [SUM_W-1:0]   tsum_nxt;
	logic               can_emit;

	assign in_ready  = (state_q == S_LOAD);
	assign load_acc  = in_valid && in_ready;
	assign nload_inc = nload_q + CNT_W'(1);
	assign set_close = is_last_job || (nload_inc == CNT_W'(PROCS));

	assign arr_rd   = job_rd_q[JOB_W-1:BURST_W];
	assign burst_rd = job_rd_q[BURST_W-1:0];

	// Run for the smaller of remaining time and quantum; zero quantum acts as one
	assign q_eff    = (quantum == '0) ? BURST_W'(1) : quantum;
	assign run      = (rem_rd_q < q_eff) ? rem_rd_q : q_eff;
	assign rem_new  = rem_rd_q - run;
	assign arr_due  = CLK_W'(arr_rd) <= clock_q;
	assign runnable = !fin_q[slot_q] && arr_due;

	assign slot_inc = CNT_W'(slot_q) + CNT_W'(1);
	assign scan_inc = CNT_W'(scan_q) + CNT_W'(1);

	// Earliest arrival later than the clock among unfinished jobs
	assign scan_hit  = !fin_q[scan_q] && (CLK_W'(arr_rd) > clock_q) &&
		(!found_q || (arr_rd < best_q));
	assign best_nxt  = scan_hit ? arr_rd : best_q;
	assign found_nxt = found_q || scan_hit;

	assign wsum_nxt = wsum_q + SUM_W'(wt_q);
	assign tsum_nxt = tsum_q + SUM_W'(tat_q);
	assign can_emit = emit_q < EMIT_W'(MAX_RESULTS);

	// Select the memory read address
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = slot_q;
		case (state_q)
			S_READ: begin
				rd_en = 1'b1;
			end
			S_NEXT: begin
				rd_en   = slot_inc < nload_q;
				rd_addr = IDX_W'(slot_inc);
			end
			S_SCAN_RD: begin
				rd_en   = 1'b1;
				rd_addr = scan_q;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// Select the remaining-time write: load fills, a run updates
	always_comb begin
		rem_we    = 1'b0;
		rem_addr  = slot_q;
		rem_wdata = rem_new;
		if (load_acc) begin
			rem_we    = 1'b1;
			rem_addr  = nload_q[IDX_W-1:0];
			rem_wdata = burst_length;
		end else if (state_q == S_EXEC && runnable) begin
			rem_we = 1'b1;
		end
	end

	// Memory ports
	always_ff @(posedge clk) begin
		if (load_acc) begin
			job_mem[nload_q[IDX_W-1:0]] <= {arrival_time, burst_length};
		end
		if (rem_we) begin
			rem_mem[rem_addr] <= rem_wdata;
		end
		if (rd_en) begin
			job_rd_q <= job_mem[rd_addr];
			rem_rd_q <= rem_mem[rd_addr];
		end
	end

	// Result of the completion waiting in S_OUT
	assign res_load = (state_q == S_OUT) && res_free && can_emit;
	always_comb begin
		res.job_index        = IDXO_W'(slot_q);
		res.turnaround       = TAT_W'(tat_q);
		res.waiting          = TAT_W'(wt_q);
		res.total_waiting    = wsum_nxt;
		res.total_turnaround = tsum_nxt;
		res.last_result      = (left_q == CNT_W'(1));
	end

	// Advance the load and walk sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			slot_q  <= '0;
			scan_q  <= '0;
			nload_q <= '0;
			left_q  <= '0;
			clock_q <= '0;
			wsum_q  <= '0;
			tsum_q  <= '0;
			fin_q   <= '0;
			prog_q  <= 1'b0;
			best_q  <= '0;
			found_q <= 1'b0;
			tat_q   <= '0;
			wt_q    <= '0;
			emit_q  <= '0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (load_acc) begin
						nload_q <= nload_inc;
						if (set_close) begin
							left_q  <= nload_inc;
							slot_q  <= '0;
							prog_q  <= 1'b0;
							emit_q  <= '0;
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (runnable) begin
						clock_q <= clock_q + CLK_W'(run);
						prog_q  <= 1'b1;
						state_q <= (rem_new == '0) ? S_TAT : S_NEXT;
					end else begin
						state_q <= S_NEXT;
					end
				end
				S_TAT: begin
					tat_q   <= clock_q - CLK_W'(arr_rd);
					state_q <= S_WT;
				end
				S_WT: begin
					wt_q    <= tat_q - CLK_W'(burst_rd);
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (res_free) begin
						left_q <= left_q - CNT_W'(1);
						if (can_emit) begin
							emit_q <= emit_q + EMIT_W'(1);
						end
						if (left_q == CNT_W'(1)) begin
							// Drop the set and wait for the next one
							nload_q <= '0;
							clock_q <= '0;
							wsum_q  <= '0;
							tsum_q  <= '0;
							fin_q   <= '0;
							state_q <= S_LOAD;
						end else begin
							fin_q[slot_q] <= 1'b1;
							wsum_q        <= wsum_nxt;
							tsum_q        <= tsum_nxt;
							state_q       <= S_NEXT;
						end
					end
				end
				S_NEXT: begin
					if (slot_inc < nload_q) begin
						state_q <= S_CHECK;
					end else if (!prog_q) begin
						scan_q  <= '0;
						found_q <= 1'b0;
						state_q <= S_SCAN_RD;
					end else begin
						prog_q  <= 1'b0;
						slot_q  <= '0;
						state_q <= S_READ;
					end
				end
				S_CHECK: begin
					// Next slot arrived: step on; if nothing ran, scan; else wrap to 0
					if (arr_due) begin
						slot_q  <= IDX_W'(slot_inc);
						state_q <= S_EXEC;
					end else if (!prog_q) begin
						scan_q  <= '0;
						found_q <= 1'b0;
						state_q <= S_SCAN_RD;
					end else begin
						prog_q  <= 1'b0;
						slot_q  <= '0;
						state_q <= S_READ;
					end
				end
				S_SCAN_RD: begin
					state_q <= S_SCAN_CMP;
				end
				S_SCAN_CMP: begin
					best_q  <= best_nxt;
					found_q <= found_nxt;
					if (scan_inc >= nload_q) begin
						if (found_nxt) begin
							clock_q <= CLK_W'(best_nxt);
						end
						prog_q  <= 1'b0;
						slot_q  <= '0;
						state_q <= S_READ;
					end else begin
						scan_q  <= IDX_W'(scan_inc);
						state_q <= S_SCAN_RD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/round_robin_completion_scheduler_top.sv
// Round-robin completion scheduler: job input, quantum write port and
// result output register around the walk engine. Depends on rrcs_pkg, rrcs_engine.
//
// Usage: jobs enter on the in channel (valid/ready), one per cycle while the
// block is loading. A job with is_last_job set, or the job that fills the
// last of PROCS slots, closes the set; the block then stops taking jobs and
// walks the set in round-robin order with a quantum of cfg_data units,
// written beforehand on the cfg channel (always ready). Each finished job
// gives one item on the out channel in completion order; the last carries
// last_result, after which loading resumes in the same cycle.
// Steps: a visit to a slot takes a memory read, a run and a look at the
// next slot, a completion adds the turnaround, waiting and output steps, and
// a pass that runs nothing scans the arrival memory, one read and compare per
// loaded slot, before jumping the clock. The single-port memory read sets them.
// A result waits in the output register; while the receiver stalls, the
// block holds the next completion and does not advance.
// Reset clears all control state and sets the quantum to 4; the job
// memories need no clearing because only loaded slots are read.
`timescale 1ns / 1ps
`default_nettype none

module round_robin_completion_scheduler_top
	import rrcs_pkg::*;
#(
	parameter int PROCS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [QNT_W-1:0]   cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [ARR_W-1:0]   arrival_time,
	input  wire logic [BURST_W-1:0] burst_length,
	input  wire logic               is_last_job,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [IDXO_W-1:0]       job_index,
	output logic [TAT_W-1:0]        turnaround,
	output logic [TAT_W-1:0]        waiting,
	output logic [SUM_W-1:0]        total_waiting,
	output logic [SUM_W-1:0]        total_turnaround,
	output logic                    last_result
);

	logic [QNT_W-1:0] quantum_q;
	logic             out_valid_q;
	result_t          res_q;
	result_t          res;
	logic             res_load;
	logic             res_free;

	// Hold the quantum register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= QNT_RESET;
		end else if (cfg_valid) begin
			quantum_q <= cfg_data;
		end
	end

	rrcs_engine #(
		.PROCS (PROCS)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.arrival_time (arrival_time),
		.burst_length (burst_length),
		.is_last_job  (is_last_job),
		.quantum      (quantum_q),
		.res_free     (res_free),
		.res_load     (res_load),
		.res          (res)
	);

	// Output register: take a new item when empty or being drained
	assign res_free = !out_valid_q || out_ready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res;
		end
	end

	assign out_valid        = out_valid_q;
	assign job_index        = res_q.job_index;
	assign turnaround       = res_q.turnaround;
	assign waiting          = res_q.waiting;
	assign total_waiting    = res_q.total_waiting;
	assign total_turnaround = res_q.total_turnaround;
	assign last_result      = res_q.last_result;

endmodule

`default_nettype wire

// File: rtl/rrcs_checker.sv
// Port-level checks of the round-robin completion scheduler and their bind.
// Depends on rrcs_pkg and round_robin_completion_scheduler_top.
`timescale 1ns / 1ps
`default_nettype none

module rrcs_checker
	import rrcs_pkg::*;
#(
	parameter int PROCS = 16
) (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire logic              is_last_job,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic [IDXO_W-1:0] job_index,
	input wire logic [TAT_W-1:0]  turnaround,
	input wire logic [TAT_W-1:0]  waiting,
	input wire logic              last_result
);

	// A stalled result item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(job_index) &&
			$stable(turnaround) && $stable(waiting) && $stable(last_result))
		else $error("result item changed while stalled");

	// Closing a set with is_last_job stops loading
	a_close_stops_load: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && is_last_job |=> !in_ready)
		else $error("loading continued after the set was closed");

	// A pending result that is not the last one means the walk is still busy
	a_busy_mid_set: assert property (@(posedge clk) disable iff (!arst_n)
		(PROCS <= MAX_RESULTS) && out_valid && !last_result |-> !in_ready)
		else $error("loading reopened before the set finished");

	// Waiting time never exceeds turnaround
	a_wait_le_tat: assert property (@(posedge clk) disable iff (!arst_n)
		(PROCS <= MAX_RESULTS) && out_valid |-> waiting <= turnaround)
		else $error("waiting time above turnaround");

endmodule

bind round_robin_completion_scheduler_top rrcs_checker #(
	.PROCS (PROCS)
) u_rrcs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.is_last_job (is_last_job),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.job_index   (job_index),
	.turnaround  (turnaround),
	.waiting     (waiting),
	.last_result (last_result)
);

`default_nettype wire
